@@ design/rdq_pkg.sv @@
// ----------------------------------------------------------------------------
// Reversible deque engine package
// Shared types, codes and default sizes for the deque controller and datapath.
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int RdqDepth      = 64;
  localparam int RdqValueWidth = 16;

  localparam int KindW   = 3;
  localparam int ValueW  = 16;
  localparam int StatusW = 2;
  localparam int ElemW   = 16;

  typedef enum logic [KindW-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_LOAD   = 3'd1,
    KIND_TOGGLE = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_DRAIN  = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_ELEM  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ERR   = 2'd2,
    STAT_OVF   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SET_OVF,
    OP_TOGGLE,
    OP_DELETE,
    OP_SET_ERR,
    OP_EMIT_ERR,
    OP_EMIT_OVF,
    OP_EMIT_EMPTY,
    OP_DRAIN_FIRST,
    OP_DRAIN_NEXT
  } dp_op_e;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ElemW-1:0]   element;
    logic               last;
  } res_item_t;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
    logic err;
    logic ovf;
    logic rem_one;
  } dp_status_t;

endpackage

@@ design/rdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Reversible deque controller
// Decodes accepted commands against the queue status and sequences drains.
// ----------------------------------------------------------------------------
module rdq_ctrl import rdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KindW-1:0] kind_i,
  input  dp_status_t       stat_i,
  output dp_cmd_t          cmd_o,
  output logic             busy_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KIND_DRAIN) && !stat_i.err && !stat_i.ovf &&
            !stat_i.empty && !stat_i.single) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.rem_one) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_CLEAR:  cmd_o.op = OP_CLEAR;
            KIND_LOAD:   cmd_o.op = stat_i.err  ? OP_NONE :
                                    stat_i.full ? OP_SET_OVF : OP_LOAD;
            KIND_TOGGLE: cmd_o.op = stat_i.err ? OP_NONE : OP_TOGGLE;
            KIND_DELETE: cmd_o.op = stat_i.err   ? OP_NONE :
                                    stat_i.empty ? OP_SET_ERR : OP_DELETE;
            KIND_DRAIN:  cmd_o.op = stat_i.err   ? OP_EMIT_ERR :
                                    stat_i.ovf   ? OP_EMIT_OVF :
                                    stat_i.empty ? OP_EMIT_EMPTY : OP_DRAIN_FIRST;
            default:     cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_DRAIN: cmd_o.op = OP_DRAIN_NEXT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q == S_DRAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/rdq_datapath.sv @@
// ----------------------------------------------------------------------------
// Reversible deque datapath
// Element memory, ring pointers, sticky flags, drain walker and result register.
// ----------------------------------------------------------------------------
module rdq_datapath import rdq_pkg::*; #(
  parameter int DEPTH       = RdqDepth,
  parameter int VALUE_WIDTH = RdqValueWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [ValueW-1:0] value_i,
  output dp_status_t        stat_o,
  output logic              res_valid_o,
  output res_item_t         res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DepthW   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);
  localparam logic [CW-1:0] OneCnt   = CW'(1);

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_q;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d, err_q, err_d, ovf_q, ovf_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          res_valid_q, res_valid_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic          res_last_q, res_last_d;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr, first_slot;
  logic [VALUE_WIDTH-1:0] wr_data;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_slot(logic [AW-1:0] p);
    return (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_slot(logic [AW-1:0] p);
    return (p == '0) ? LastSlot : p - 1'b1;
  endfunction

  assign wr_data    = VALUE_WIDTH'(value_i);
  assign wr_addr    = rev_q ? dec_slot(head_q) : wrap_add(head_q, AW'(count_q));
  assign first_slot = rev_q ? wrap_add(head_q, AW'(count_q - OneCnt)) : head_q;

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    rev_d        = rev_q;
    err_d        = err_q;
    ovf_d        = ovf_q;
    ptr_d        = ptr_q;
    rem_d        = rem_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q;
    wr_en        = 1'b0;
    case (cmd_i.op)
      OP_CLEAR: begin
        head_d  = '0;
        count_d = '0;
        rev_d   = 1'b0;
        err_d   = 1'b0;
        ovf_d   = 1'b0;
      end
      OP_LOAD: begin
        wr_en   = 1'b1;
        count_d = count_q + OneCnt;
        if (rev_q) begin
          head_d = dec_slot(head_q);
        end
      end
      OP_SET_OVF: ovf_d = 1'b1;
      OP_TOGGLE:  rev_d = !rev_q;
      OP_DELETE: begin
        count_d = count_q - OneCnt;
        if (!rev_q) begin
          head_d = inc_slot(head_q);
        end
      end
      OP_SET_ERR: err_d = 1'b1;
      OP_EMIT_ERR: begin
        res_valid_d  = 1'b1;
        res_status_d = STAT_ERR;
        res_last_d   = 1'b1;
      end
      OP_EMIT_OVF: begin
        res_valid_d  = 1'b1;
        res_status_d = STAT_OVF;
        res_last_d   = 1'b1;
        head_d       = '0;
        count_d      = '0;
      end
      OP_EMIT_EMPTY: begin
        res_valid_d  = 1'b1;
        res_status_d = STAT_EMPTY;
        res_last_d   = 1'b1;
        head_d       = '0;
        count_d      = '0;
      end
      OP_DRAIN_FIRST: begin
        rd_en        = 1'b1;
        rd_addr      = first_slot;
        ptr_d        = rev_q ? dec_slot(first_slot) : inc_slot(first_slot);
        rem_d        = count_q - OneCnt;
        res_valid_d  = 1'b1;
        res_status_d = STAT_ELEM;
        res_last_d   = (count_q == OneCnt);
        if (count_q == OneCnt) begin
          head_d  = '0;
          count_d = '0;
        end
      end
      OP_DRAIN_NEXT: begin
        rd_en        = 1'b1;
        rd_addr      = ptr_q;
        ptr_d        = rev_q ? dec_slot(ptr_q) : inc_slot(ptr_q);
        rem_d        = rem_q - OneCnt;
        res_valid_d  = 1'b1;
        res_status_d = STAT_ELEM;
        res_last_d   = (rem_q == OneCnt);
        if (rem_q == OneCnt) begin
          head_d  = '0;
          count_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      rev_q        <= 1'b0;
      err_q        <= 1'b0;
      ovf_q        <= 1'b0;
      ptr_q        <= '0;
      rem_q        <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= STAT_ELEM;
      res_last_q   <= 1'b0;
    end else begin
      head_q       <= head_d;
      count_q      <= count_d;
      rev_q        <= rev_d;
      err_q        <= err_d;
      ovf_q        <= ovf_d;
      ptr_q        <= ptr_d;
      rem_q        <= rem_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
    end
  end

  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q == FullCnt);
  assign stat_o.single  = (count_q == OneCnt);
  assign stat_o.err     = err_q;
  assign stat_o.ovf     = ovf_q;
  assign stat_o.rem_one = (rem_q == OneCnt);

  assign res_valid_o    = res_valid_q;
  assign res_o.status   = res_status_q;
  assign res_o.element  = (res_status_q == STAT_ELEM) ? ElemW'(rd_q) : '0;
  assign res_o.last     = res_last_q;

endmodule

@@ design/reversible_deque_engine.sv @@
// ----------------------------------------------------------------------------
// Reversible deque engine
// Ring-buffer double-ended queue with a lazy reverse flag and sticky flags.
// ----------------------------------------------------------------------------
// Clear, load, toggle and delete may follow back to back.
// A drain result appears in the cycle after acceptance; a drain of more than one
// element holds busy while it yields one element per cycle through the single
// read port of the element memory. Results cannot be stalled.
// Reset clears pointers, count and flags at once; the element memory is not cleared.
module reversible_deque_engine import rdq_pkg::*; #(
  parameter int DEPTH       = RdqDepth,
  parameter int VALUE_WIDTH = RdqValueWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  cmd_i,
  output logic      res_valid_o,
  output res_item_t res_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_stat;

  rdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (cmd_i.kind),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy_o (busy)
  );

  rdq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .value_i    (cmd_i.value),
    .stat_o     (dp_stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Every accepted drain yields a result transfer in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.kind == KIND_DRAIN)) |=> res_valid_o)
    else $error("drain accepted without a result");

  // While a drain runs, a result is delivered in every following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_valid_o)
    else $error("drain gap in result stream");

  // The final result of a drain coincides with the engine being free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy)
    else $error("busy after last result");

  // Status results are single and carry no element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != STAT_ELEM)) |-> (res_o.last && (res_o.element == '0)))
    else $error("malformed status result");

endmodule
